### rtl/core/bpbb_pkg.sv
// bpbb_pkg: widths, lerp slot codes and the controller/datapath command and
// status structs for the path bounding box core
// no dependencies
package bpbb_pkg;

  // coordinate format, signed q16.16
  localparam int CW    = 32;
  localparam int FW    = 16;
  // fraction bits of the curve parameter t
  localparam int TB    = 62 - CW;
  // control-point differences after the nudge
  localparam int MW    = CW + 2;
  // multiplier product
  localparam int PW    = 2 * MW;
  // numerator, denominator and root candidates
  localparam int NW    = CW + 5;
  // square root result and remainder
  localparam int RTW   = PW / 2;
  localparam int RW    = RTW + 4;
  // 0.01 in the coordinate format, rounded to nearest
  localparam int NUDGE = ((1 << FW) + 50) / 100;
  // iteration counter
  localparam int CNTW  = 6;
  localparam int LIW   = 3;

  // de casteljau slots, each a lerp of two earlier values
  localparam logic [LIW-1:0] LERP_Q0  = 3'd0;
  localparam logic [LIW-1:0] LERP_Q1  = 3'd1;
  localparam logic [LIW-1:0] LERP_Q2  = 3'd2;
  localparam logic [LIW-1:0] LERP_R0  = 3'd3;
  localparam logic [LIW-1:0] LERP_R1  = 3'd4;
  localparam logic [LIW-1:0] LERP_OUT = 3'd5;

  typedef struct packed {
    logic           load;
    logic           widen_pt;
    logic           axis;
    logic           ax_init;
    logic           mul_bb;
    logic           mul_ac;
    logic           disc;
    logic           sq_step;
    logic           root_sel;
    logic           root_chk;
    logic           dv_step;
    logic           lerp_mul;
    logic           lerp_add;
    logic [LIW-1:0] lerp_idx;
    logic           span_widen;
    logic           merge;
    logic           emit;
  } bpbb_cmd_t;

  typedef struct packed {
    logic need_roots;
    logic disc_ok;
    logic root_ok;
  } bpbb_sts_t;

endpackage

### rtl/core/bpbb_dp.sv
// bpbb_dp: datapath of the path bounding box core, running box, shared
// multiplier, bit-serial square root and divider, de casteljau registers
// depends on bpbb_pkg
module bpbb_dp import bpbb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bpbb_cmd_t            cmd_i,
  output bpbb_sts_t            sts_o,
  input  logic signed [CW-1:0] start_x_i,
  input  logic signed [CW-1:0] start_y_i,
  input  logic signed [CW-1:0] ctrl1_x_i,
  input  logic signed [CW-1:0] ctrl1_y_i,
  input  logic signed [CW-1:0] ctrl2_x_i,
  input  logic signed [CW-1:0] ctrl2_y_i,
  input  logic signed [CW-1:0] end_x_i,
  input  logic signed [CW-1:0] end_y_i,
  output logic signed [CW-1:0] box_left_o,
  output logic signed [CW-1:0] box_top_o,
  output logic        [CW-1:0] box_width_o,
  output logic        [CW-1:0] box_height_o
);

  localparam logic signed [CW-1:0] MAXV = {1'b0, {(CW-1){1'b1}}};
  localparam logic signed [CW-1:0] MINV = {1'b1, {(CW-1){1'b0}}};

  logic signed [CW-1:0] sx_q, sy_q, c1x_q, c1y_q, c2x_q, c2y_q, ex_q, ey_q;
  logic signed [CW-1:0] min_x_q, min_y_q, max_x_q, max_y_q;
  logic signed [CW-1:0] lo_q, hi_q;
  logic signed [MW-1:0] a_q, b_q, c_q;
  logic signed [NW-1:0] n_q, d_q;
  logic                 need_q;
  logic signed [PW-1:0] prod_q, bb_q;
  logic        [PW-1:0] sq_op_q;
  logic        [RW-1:0] sq_rem_q;
  logic       [RTW-1:0] sq_root_q;
  logic        [NW-1:0] dv_rem_q, dv_den_q;
  logic        [TB-1:0] dv_quo_q;
  logic signed [CW-1:0] lx_q;
  logic signed [CW-1:0] lv_q [6];
  logic signed [CW-1:0] left_q, top_q;
  logic        [CW-1:0] width_q, height_q;

  logic signed [CW-1:0] p0, p1, p2, p3, lo_w, hi_w;
  logic signed [MW-1:0] a_w, b_w, c_w, bn_w;
  logic signed [NW-1:0] n_w, d_w;
  logic signed [MW-1:0] ma, mb, ldiff;
  logic signed [PW-1:0] prod_w, disc_w;
  logic        [RW-1:0] rem2, trial;
  logic signed [NW-1:0] r_w, m_w;
  logic        [NW-1:0] m_mag, d_mag;
  logic          [NW:0] dv_r2;
  logic signed [CW-1:0] lsx, lsy, lerp_w, v_w;
  logic          [CW:0] wdiff, hdiff;

  // current axis
  assign p0 = cmd_i.axis ? sy_q  : sx_q;
  assign p1 = cmd_i.axis ? c1y_q : c1x_q;
  assign p2 = cmd_i.axis ? c2y_q : c2x_q;
  assign p3 = cmd_i.axis ? ey_q  : ex_q;

  assign lo_w = (p0 < p3) ? p0 : p3;
  assign hi_w = (p0 < p3) ? p3 : p0;
  assign a_w  = MW'(p1) - MW'(p0);
  assign b_w  = MW'(p2) - MW'(p1);
  assign c_w  = MW'(p3) - MW'(p2);
  assign bn_w = ((a_w + c_w) != (b_w <<< 1)) ? b_w + MW'(NUDGE) : b_w;
  assign n_w  = NW'(a_w) - NW'(bn_w);
  assign d_w  = NW'(a_w) - (NW'(bn_w) <<< 1) + NW'(c_w);

  // lerp operands
  always_comb begin
    case (cmd_i.lerp_idx)
      LERP_Q0:  begin lsx = p0;       lsy = p1;       end
      LERP_Q1:  begin lsx = p1;       lsy = p2;       end
      LERP_Q2:  begin lsx = p2;       lsy = p3;       end
      LERP_R0:  begin lsx = lv_q[0];  lsy = lv_q[1];  end
      LERP_R1:  begin lsx = lv_q[1];  lsy = lv_q[2];  end
      default:  begin lsx = lv_q[3];  lsy = lv_q[4];  end
    endcase
  end
  assign ldiff = MW'(lsy) - MW'(lsx);

  // shared multiplier
  always_comb begin
    if (cmd_i.mul_bb) begin
      ma = b_q;
      mb = b_q;
    end else if (cmd_i.mul_ac) begin
      ma = a_q;
      mb = c_q;
    end else begin
      ma = ldiff;
      mb = signed'(MW'(dv_quo_q));
    end
  end
  assign prod_w = ma * mb;
  assign lerp_w = lx_q + CW'(prod_q >>> TB);

  assign disc_w = bb_q - prod_q;

  // square root, two radicand bits a step
  assign rem2  = {sq_rem_q[RW-3:0], sq_op_q[PW-1:PW-2]};
  assign trial = RW'({sq_root_q, 2'b01});

  // root candidates
  assign r_w   = signed'(NW'(sq_root_q));
  assign m_w   = cmd_i.root_sel ? n_q - r_w : n_q + r_w;
  assign m_mag = m_w[NW-1] ? NW'(-m_w) : NW'(m_w);
  assign d_mag = d_q[NW-1] ? NW'(-d_q) : NW'(d_q);

  assign dv_r2 = {dv_rem_q, 1'b0};
  assign v_w   = lv_q[5];

  assign sts_o.need_roots = need_q;
  assign sts_o.disc_ok    = !disc_w[PW-1] && (d_q != '0);
  assign sts_o.root_ok    = (m_w != '0) && (m_w[NW-1] == d_q[NW-1]) && (m_mag < d_mag);

  assign wdiff = (CW+1)'(max_x_q) - (CW+1)'(min_x_q);
  assign hdiff = (CW+1)'(max_y_q) - (CW+1)'(min_y_q);

  // running box
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_x_q <= MAXV;
      min_y_q <= MAXV;
      max_x_q <= MINV;
      max_y_q <= MINV;
    end else if (cmd_i.emit) begin
      min_x_q <= MAXV;
      min_y_q <= MAXV;
      max_x_q <= MINV;
      max_y_q <= MINV;
    end else if (cmd_i.widen_pt) begin
      if (sx_q < min_x_q) min_x_q <= sx_q;
      if (sx_q > max_x_q) max_x_q <= sx_q;
      if (sy_q < min_y_q) min_y_q <= sy_q;
      if (sy_q > max_y_q) max_y_q <= sy_q;
    end else if (cmd_i.merge) begin
      if (cmd_i.axis) begin
        if (lo_q < min_y_q) min_y_q <= lo_q;
        if (hi_q > max_y_q) max_y_q <= hi_q;
      end else begin
        if (lo_q < min_x_q) min_x_q <= lo_q;
        if (hi_q > max_x_q) max_x_q <= hi_q;
      end
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sx_q  <= start_x_i;
      sy_q  <= start_y_i;
      c1x_q <= ctrl1_x_i;
      c1y_q <= ctrl1_y_i;
      c2x_q <= ctrl2_x_i;
      c2y_q <= ctrl2_y_i;
      ex_q  <= end_x_i;
      ey_q  <= end_y_i;
    end
    if (cmd_i.ax_init) begin
      lo_q   <= lo_w;
      hi_q   <= hi_w;
      need_q <= (p1 < lo_w) || (p1 > hi_w) || (p2 < lo_w) || (p2 > hi_w);
      a_q    <= a_w;
      b_q    <= bn_w;
      c_q    <= c_w;
      n_q    <= n_w;
      d_q    <= d_w;
    end else if (cmd_i.span_widen) begin
      if (v_w < lo_q) lo_q <= v_w;
      if (v_w > hi_q) hi_q <= v_w;
    end
    if (cmd_i.mul_bb || cmd_i.mul_ac || cmd_i.lerp_mul) begin
      prod_q <= prod_w;
    end
    if (cmd_i.mul_ac) begin
      bb_q <= prod_q;
    end
    if (cmd_i.lerp_mul) begin
      lx_q <= lsx;
    end
    if (cmd_i.lerp_add) begin
      lv_q[cmd_i.lerp_idx] <= lerp_w;
    end
    if (cmd_i.disc) begin
      sq_op_q   <= PW'(disc_w);
      sq_rem_q  <= '0;
      sq_root_q <= '0;
    end else if (cmd_i.sq_step) begin
      sq_op_q <= {sq_op_q[PW-3:0], 2'b00};
      if (rem2 >= trial) begin
        sq_rem_q  <= rem2 - trial;
        sq_root_q <= {sq_root_q[RTW-2:0], 1'b1};
      end else begin
        sq_rem_q  <= rem2;
        sq_root_q <= {sq_root_q[RTW-2:0], 1'b0};
      end
    end
    if (cmd_i.root_chk) begin
      dv_rem_q <= m_mag;
      dv_den_q <= d_mag;
      dv_quo_q <= '0;
    end else if (cmd_i.dv_step) begin
      if (dv_r2 >= {1'b0, dv_den_q}) begin
        dv_rem_q <= NW'(dv_r2 - {1'b0, dv_den_q});
        dv_quo_q <= {dv_quo_q[TB-2:0], 1'b1};
      end else begin
        dv_rem_q <= NW'(dv_r2);
        dv_quo_q <= {dv_quo_q[TB-2:0], 1'b0};
      end
    end
    if (cmd_i.emit) begin
      left_q   <= min_x_q;
      top_q    <= min_y_q;
      width_q  <= (max_x_q <= min_x_q) ? '0 : wdiff[CW-1:0];
      height_q <= (max_y_q <= min_y_q) ? '0 : hdiff[CW-1:0];
    end
  end

  assign box_left_o   = left_q;
  assign box_top_o    = top_q;
  assign box_width_o  = width_q;
  assign box_height_o = height_q;

endmodule

### rtl/core/bpbb_ctrl.sv
// bpbb_ctrl: sequencer of the path bounding box core, handshakes and the
// per-axis root solving schedule
// depends on bpbb_pkg
module bpbb_ctrl import bpbb_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  logic      kind_i,
  input  logic      last_element_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output bpbb_cmd_t cmd_o,
  input  bpbb_sts_t sts_i
);

  typedef enum logic [3:0] {
    ST_IDLE, ST_POINT, ST_AX_INIT, ST_MUL_BB, ST_MUL_AC, ST_DISC, ST_SQRT,
    ST_ROOT, ST_DIV, ST_LMUL, ST_LADD, ST_WIDEN, ST_MERGE, ST_FINISH
  } state_e;

  state_e          state_q;
  logic            axis_q, k_q, last_q, out_valid_q;
  logic [LIW-1:0]  li_q;
  logic [CNTW-1:0] cnt_q;
  logic            emit_ok;

  assign in_ready_o  = (state_q == ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign emit_ok     = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o            = '0;
    cmd_o.axis       = axis_q;
    cmd_o.root_sel   = k_q;
    cmd_o.lerp_idx   = li_q;
    case (state_q)
      ST_IDLE:    cmd_o.load       = in_valid_i;
      ST_POINT:   cmd_o.widen_pt   = 1'b1;
      ST_AX_INIT: cmd_o.ax_init    = 1'b1;
      ST_MUL_BB:  cmd_o.mul_bb     = sts_i.need_roots;
      ST_MUL_AC:  cmd_o.mul_ac     = 1'b1;
      ST_DISC:    cmd_o.disc       = 1'b1;
      ST_SQRT:    cmd_o.sq_step    = 1'b1;
      ST_ROOT:    cmd_o.root_chk   = 1'b1;
      ST_DIV:     cmd_o.dv_step    = 1'b1;
      ST_LMUL:    cmd_o.lerp_mul   = 1'b1;
      ST_LADD:    cmd_o.lerp_add   = 1'b1;
      ST_WIDEN:   cmd_o.span_widen = 1'b1;
      ST_MERGE:   cmd_o.merge      = 1'b1;
      ST_FINISH:  cmd_o.emit       = last_q && emit_ok;
      default:    cmd_o.load       = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      axis_q      <= 1'b0;
      k_q         <= 1'b0;
      last_q      <= 1'b0;
      li_q        <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && !cmd_o.emit) out_valid_q <= 1'b0;
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            last_q  <= last_element_i;
            axis_q  <= 1'b0;
            state_q <= kind_i ? ST_AX_INIT : ST_POINT;
          end
        end
        ST_POINT:   state_q <= ST_FINISH;
        ST_AX_INIT: state_q <= ST_MUL_BB;
        ST_MUL_BB:  state_q <= sts_i.need_roots ? ST_MUL_AC : ST_MERGE;
        ST_MUL_AC:  state_q <= ST_DISC;
        ST_DISC: begin
          cnt_q   <= '0;
          k_q     <= 1'b0;
          state_q <= sts_i.disc_ok ? ST_SQRT : ST_MERGE;
        end
        ST_SQRT: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CNTW'(RTW - 1)) state_q <= ST_ROOT;
        end
        ST_ROOT: begin
          cnt_q <= '0;
          if (sts_i.root_ok) begin
            state_q <= ST_DIV;
          end else if (k_q) begin
            state_q <= ST_MERGE;
          end else begin
            k_q <= 1'b1;
          end
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          li_q  <= LERP_Q0;
          if (cnt_q == CNTW'(TB - 1)) state_q <= ST_LMUL;
        end
        ST_LMUL: state_q <= ST_LADD;
        ST_LADD: begin
          if (li_q == LERP_OUT) begin
            state_q <= ST_WIDEN;
          end else begin
            li_q    <= li_q + 1'b1;
            state_q <= ST_LMUL;
          end
        end
        ST_WIDEN: begin
          if (k_q) begin
            state_q <= ST_MERGE;
          end else begin
            k_q     <= 1'b1;
            state_q <= ST_ROOT;
          end
        end
        ST_MERGE: begin
          if (axis_q) begin
            state_q <= ST_FINISH;
          end else begin
            axis_q  <= 1'b1;
            state_q <= ST_AX_INIT;
          end
        end
        ST_FINISH: begin
          if (!last_q) begin
            state_q <= ST_IDLE;
          end else if (emit_ok) begin
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

### rtl/core/bezier_path_bounding_box_core.sv
// bezier_path_bounding_box_core: top level, sequencer plus datapath
// depends on bpbb_pkg, bpbb_ctrl, bpbb_dp
//
// Bounding box of a path of points and cubic bezier curves in signed q16.16.
// Elements arrive one transaction at a time; the element flagged last_element
// produces one result transaction (left, top, width, height) and clears the
// running box for the next path. A curve element is handled per axis in turn:
// an axis whose control points sit inside the endpoint span skips the root
// solving; otherwise the shared 34x34 multiplier forms the discriminant, a
// bit-serial square root follows, and each root candidate in (0,1) takes a
// restoring divide and then de casteljau lerps on the same multiplier. The
// next element is accepted only after the previous one is finished. A finished
// result is held in the output register while the next path is accepted;
// only a further last element waits for that result to be taken.
module bezier_path_bounding_box_core import bpbb_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic                 kind_i,
  input  logic signed [CW-1:0] start_x_i,
  input  logic signed [CW-1:0] start_y_i,
  input  logic signed [CW-1:0] ctrl1_x_i,
  input  logic signed [CW-1:0] ctrl1_y_i,
  input  logic signed [CW-1:0] ctrl2_x_i,
  input  logic signed [CW-1:0] ctrl2_y_i,
  input  logic signed [CW-1:0] end_x_i,
  input  logic signed [CW-1:0] end_y_i,
  input  logic                 last_element_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic signed [CW-1:0] box_left_o,
  output logic signed [CW-1:0] box_top_o,
  output logic        [CW-1:0] box_width_o,
  output logic        [CW-1:0] box_height_o
);

  // command and status between sequencer and datapath
  bpbb_cmd_t cmd;
  bpbb_sts_t sts;

  bpbb_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .kind_i         (kind_i),
    .last_element_i (last_element_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .cmd_o          (cmd),
    .sts_i          (sts)
  );

  bpbb_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .ctrl1_x_i    (ctrl1_x_i),
    .ctrl1_y_i    (ctrl1_y_i),
    .ctrl2_x_i    (ctrl2_x_i),
    .ctrl2_y_i    (ctrl2_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .box_left_o   (box_left_o),
    .box_top_o    (box_top_o),
    .box_width_o  (box_width_o),
    .box_height_o (box_height_o)
  );

endmodule

### tb/bezier_path_bounding_box_core_tb.sv
// bezier_path_bounding_box_core_tb: self-checking bench for the path bounding box core
// drives points and cubic curves, predicts each box in fixed point and compares results
// depends on bpbb_pkg and bezier_path_bounding_box_core
`timescale 1ns / 100ps

module bezier_path_bounding_box_core_tb;
  import bpbb_pkg::*;

  localparam int    HALF_PERIOD = 4;
  localparam int    RESET_CYCLES = 9;
  localparam int    RANDOM_ITEMS = 550;
  localparam int    CYCLE_LIMIT = 1000000;
  localparam int    DRAIN_CYCLES = 300;
  localparam bit    KIND_POINT = 1'b0;
  localparam bit    KIND_CURVE = 1'b1;
  localparam longint COORD_MAX = 64'sd2147483647;
  localparam longint COORD_MIN = -64'sd2147483648;

  typedef struct packed {
    logic        kind;
    logic [31:0] sx, sy, c1x, c1y, c2x, c2y, ex, ey;
    logic        last;
  } element_t;

  typedef struct packed {
    logic [31:0] left, top, width, height;
  } box_t;

  // directed row: element plus an optional typed-in result
  typedef struct packed {
    element_t el;
    logic     has_box;
    box_t     box;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  element_t    drv = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] box_left, box_top, box_width, box_height;

  // running box kept by the predictor
  longint lo_x, lo_y, hi_x, hi_y;
  box_t   box_q[$];
  int     n_errors = 0;
  int     cycle_cnt = 0;

  always #HALF_PERIOD clk = ~clk;

  bezier_path_bounding_box_core dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready),
    .kind_i         (drv.kind),
    .start_x_i      (drv.sx),
    .start_y_i      (drv.sy),
    .ctrl1_x_i      (drv.c1x),
    .ctrl1_y_i      (drv.c1y),
    .ctrl2_x_i      (drv.c2x),
    .ctrl2_y_i      (drv.c2y),
    .end_x_i        (drv.ex),
    .end_y_i        (drv.ey),
    .last_element_i (drv.last),
    .out_valid_o    (out_valid),
    .out_ready_i    (out_ready),
    .box_left_o     (box_left),
    .box_top_o      (box_top),
    .box_width_o    (box_width),
    .box_height_o   (box_height)
  );

  function automatic longint sx32(logic [31:0] v);
    return longint'(signed'(v));
  endfunction

  function automatic void clear_box();
    lo_x = COORD_MAX;
    lo_y = COORD_MAX;
    hi_x = COORD_MIN;
    hi_y = COORD_MIN;
  endfunction

  // floor(p / 2^TB) for signed p
  function automatic longint floor_shift(longint p);
    return p >>> TB;
  endfunction

  function automatic longint lerp_t(longint a, longint b, longint t);
    return a + floor_shift((b - a) * t);
  endfunction

  function automatic longint curve_at(longint p0, longint p1, longint p2, longint p3,
                                      longint t);
    longint q0, q1, q2;
    q0 = lerp_t(p0, p1, t);
    q1 = lerp_t(p1, p2, t);
    q2 = lerp_t(p2, p3, t);
    return lerp_t(lerp_t(q0, q1, t), lerp_t(q1, q2, t), t);
  endfunction

  // span of one axis of a curve, merged into the running box
  function automatic void curve_span(longint p0, longint p1, longint p2, longint p3,
                                     ref longint run_lo, ref longint run_hi);
    longint lo, hi, a, b, c, n, d, m, r;
    logic signed [127:0] disc;
    logic [127:0] rl, rh, md;
    lo = (p0 < p3) ? p0 : p3;
    hi = (p0 < p3) ? p3 : p0;
    if (p1 < lo || p1 > hi || p2 < lo || p2 > hi) begin
      a = p1 - p0;
      b = p2 - p1;
      c = p3 - p2;
      if (a + c != 2 * b) b = b + NUDGE;
      n = a - b;
      d = a - 2 * b + c;
      disc = 128'(b) * 128'(b) - 128'(a) * 128'(c);
      // zero denominator or negative discriminant: no extremum on this axis
      if (d != 0 && disc >= 0) begin
        rl = 0;
        rh = 128'd1 << 51;
        while (rh - rl > 1) begin
          md = rl + ((rh - rl) >> 1);
          if (md * md > disc) rh = md;
          else rl = md;
        end
        r = longint'(rl);
        for (int k = 0; k < 2; k++) begin
          m = (k == 0) ? n + r : n - r;
          if (m != 0 && ((m < 0) == (d < 0)) && ((m < 0 ? -m : m) < (d < 0 ? -d : d))) begin
            // t strictly inside (0,1), quantised down to TB fraction bits
            logic [127:0] tq;
            tq = (128'(m < 0 ? -m : m) << TB) / 128'(d < 0 ? -d : d);
            m = curve_at(p0, p1, p2, p3, longint'(tq));
            if (m < lo) lo = m;
            if (m > hi) hi = m;
          end
        end
      end
    end
    if (lo < run_lo) run_lo = lo;
    if (hi > run_hi) run_hi = hi;
  endfunction

  function automatic logic [31:0] span_width(longint lo, longint hi);
    longint w;
    if (hi <= lo) return '0;
    w = hi - lo;
    return (w > 64'sd4294967295) ? 32'hFFFF_FFFF : w[31:0];
  endfunction

  // advance the predicted box by one element, queue a result on the last one
  function automatic void predict_box(element_t e);
    box_t b;
    if (e.kind == KIND_POINT) begin
      if (sx32(e.sx) < lo_x) lo_x = sx32(e.sx);
      if (sx32(e.sx) > hi_x) hi_x = sx32(e.sx);
      if (sx32(e.sy) < lo_y) lo_y = sx32(e.sy);
      if (sx32(e.sy) > hi_y) hi_y = sx32(e.sy);
    end else begin
      curve_span(sx32(e.sx), sx32(e.c1x), sx32(e.c2x), sx32(e.ex), lo_x, hi_x);
      curve_span(sx32(e.sy), sx32(e.c1y), sx32(e.c2y), sx32(e.ey), lo_y, hi_y);
    end
    if (e.last) begin
      b.left   = lo_x[31:0];
      b.top    = lo_y[31:0];
      b.width  = span_width(lo_x, hi_x);
      b.height = span_width(lo_y, hi_y);
      box_q.push_back(b);
      clear_box();
    end
  endfunction

  // random coordinate, biased towards small values and the extremes
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 9))
      0:       return 32'h8000_0000 + $urandom_range(0, 3);
      1:       return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2, 3:    return $urandom();
      default: return 32'(int'($urandom_range(0, 200000)) - 100000) << $urandom_range(0, 6);
    endcase
  endfunction

  function automatic element_t rand_element(bit last);
    element_t e;
    e.kind = ($urandom_range(0, 3) != 0) ? KIND_CURVE : KIND_POINT;
    e.sx = rand_coord();  e.sy = rand_coord();
    e.c1x = rand_coord(); e.c1y = rand_coord();
    e.c2x = rand_coord(); e.c2y = rand_coord();
    e.ex = rand_coord();  e.ey = rand_coord();
    // some curves with controls inside the endpoint span
    if (e.kind == KIND_CURVE && $urandom_range(0, 4) == 0) begin
      e.c1x = e.sx; e.c2x = e.ex; e.c1y = e.sy; e.c2y = e.ey;
    end
    e.last = last;
    return e;
  endfunction

  function automatic element_t mk(logic k, int sx, int sy, int c1x, int c1y, int c2x,
                                  int c2y, int ex, int ey, logic last);
    element_t e;
    e.kind = k; e.sx = sx; e.sy = sy; e.c1x = c1x; e.c1y = c1y;
    e.c2x = c2x; e.c2y = c2y; e.ex = ex; e.ey = ey; e.last = last;
    return e;
  endfunction

  // one transaction on the element channel, with a random burst gap first
  task automatic send_element(element_t e, bit allow_gap);
    if (allow_gap && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    drv      <= e;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    predict_box(e);
    @(negedge clk);
  endtask

  // directed rows
  row_t rows[$];

  task automatic add_row(element_t e, logic has, box_t b);
    row_t r;
    r.el = e; r.has_box = has; r.box = b;
    rows.push_back(r);
  endtask

  // receiver stall pattern, with calm stretches
  always @(negedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else if ((cycle_cnt / 2000) % 3 == 2) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 2) != 0);
  end

  // result checking at the rising edge
  always @(posedge clk) begin
    box_t exp_box;
    if (rst_n && out_valid && out_ready) begin
      if (box_q.size() == 0) begin
        $error("unexpected result transaction");
        n_errors++;
      end else begin
        exp_box = box_q.pop_front();
        if (box_left !== exp_box.left) begin
          $error("box_left exp %h got %h", exp_box.left, box_left); n_errors++;
        end
        if (box_top !== exp_box.top) begin
          $error("box_top exp %h got %h", exp_box.top, box_top); n_errors++;
        end
        if (box_width !== exp_box.width) begin
          $error("box_width exp %h got %h", exp_box.width, box_width); n_errors++;
        end
        if (box_height !== exp_box.height) begin
          $error("box_height exp %h got %h", exp_box.height, box_height); n_errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    box_t  b;
    row_t  r;
    int    left;
    clear_box();
    // points at the extremes: full-range box gives the largest width
    b = '{32'h8000_0000, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF};
    add_row(mk(KIND_POINT, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0, 0, 0), 0, '0);
    add_row(mk(KIND_POINT, 32'h7FFF_FFFF, 32'h7FFF_FFFF, -1, -1, -1, -1, -1, -1, 1), 1, b);
    // single point: zero extent
    b = '{32'h0001_0000, 32'hFFFF_0000, 32'h0, 32'h0};
    add_row(mk(KIND_POINT, 32'h0001_0000, 32'hFFFF_0000, 5, 5, 5, 5, 5, 5, 1), 1, b);
    // flat curve with controls inside the endpoints
    b = '{32'h0, 32'h0, 32'h000A_0000, 32'h0};
    add_row(mk(KIND_CURVE, 0, 0, 32'h0003_0000, 0, 32'h0006_0000, 0, 32'h000A_0000, 0, 1),
            1, b);
    // overshooting controls on the x axis, y controls inside the span
    add_row(mk(KIND_CURVE, 0, 0, 32'h0010_0000, 32'h0004_0000, 32'hFFF0_0000,
               32'h0008_0000, 32'h0002_0000, 32'h000C_0000, 0), 0, '0);
    // linear-spaced controls inside the span, so no root solving on either axis
    add_row(mk(KIND_CURVE, 0, 0, 32'hFFFF_0000, 32'h0001_0000, 32'hFFFE_0000,
               32'h0002_0000, 32'hFFFD_0000, 32'h0003_0000, 1), 0, '0);
    // both controls on one side, outside the span
    add_row(mk(KIND_CURVE, 0, 0, 32'h0020_0000, 32'h0020_0000, 32'h0020_0000,
               32'h0020_0000, 32'h0001_0000, 32'h0001_0000, 1), 0, '0);
    // extreme controls
    add_row(mk(KIND_CURVE, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 1), 0, '0);
    add_row(mk(KIND_CURVE, -1, -1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, -1,
               32'h5555_5555, 32'hAAAA_AAAA, 1), 0, '0);

    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (rows[i]) begin
      r = rows[i];
      if (r.has_box) begin
        // typed-in value takes the place of the predicted one
        send_element(r.el, 1'b1);
        if (box_q.size() != 0) box_q[box_q.size()-1] = r.box;
      end else begin
        send_element(r.el, 1'b1);
      end
    end

    // random paths of 1..6 elements, last element closes each path
    left = RANDOM_ITEMS;
    while (left > 0) begin
      int len;
      len = $urandom_range(1, 6);
      for (int j = 0; j < len && left > 0; j++) begin
        send_element(rand_element(j == len - 1 || left == 1), (cycle_cnt / 3000) % 4 != 3);
        left--;
      end
    end
    in_valid <= 1'b0;

    while (box_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (n_errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule

### filelist.f
rtl/core/bpbb_pkg.sv
rtl/core/bpbb_dp.sv
rtl/core/bpbb_ctrl.sv
rtl/core/bezier_path_bounding_box_core.sv
tb/bezier_path_bounding_box_core_tb.sv
